// ----- sv/drive_command_mixer_with_failsafe_defines.svh -----
// ----------------------------------------------------------------------------
// Drive command mixer assertion macros
// Shared concurrent assertion forms for the mixer checker.
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_MIXER_WITH_FAILSAFE_DEFINES_SVH
`define DRIVE_COMMAND_MIXER_WITH_FAILSAFE_DEFINES_SVH

// check a property outside reset
`define DCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define DCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer package
// Codes, limits and the mixer settings type.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam logic [31:0] FRAME_MAGIC = 32'h5243_0001;
  localparam logic [6:0]  DRIVE_LIMIT = 7'd100;
  localparam logic [6:0]  SERVO_LIMIT = 7'd90;
  localparam logic [16:0] MS_SAT      = 17'h1_FFFF;

  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_CONNECT = 2'd2;
  localparam logic [1:0] OP_LOST    = 2'd3;

  localparam logic [1:0] ACT_NONE        = 2'd0;
  localparam logic [1:0] ACT_SET         = 2'd1;
  localparam logic [1:0] ACT_STOP_CENTER = 2'd2;
  localparam logic [1:0] ACT_STOP        = 2'd3;

  localparam logic [2:0] REG_LEFT_GAIN    = 3'd0;
  localparam logic [2:0] REG_RIGHT_GAIN   = 3'd1;
  localparam logic [2:0] REG_FLIP_LEFT    = 3'd2;
  localparam logic [2:0] REG_FLIP_RIGHT   = 3'd3;
  localparam logic [2:0] REG_SWAP_SIDES   = 3'd4;
  localparam logic [2:0] REG_MAX_PERCENT  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_MS   = 3'd6;

  typedef struct packed {
    logic [11:0] left_gain;
    logic [11:0] right_gain;
    logic        flip_left;
    logic        flip_right;
    logic        swap_sides;
    logic [6:0]  max_percent;
  } dcm_cfg_t;

endpackage

// ----- sv/dcm_mixer.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer datapath
// Clamp, mix, Q2.10 scale, invert, limit and swap for one command frame.
// ----------------------------------------------------------------------------
module dcm_mixer import dcm_pkg::*; (
  input  logic signed [31:0] speed_request,
  input  logic signed [31:0] steer_request,
  input  logic signed [31:0] diff_request,
  input  dcm_cfg_t           cfg,
  output logic signed [7:0]  left_drive,
  output logic signed [7:0]  right_drive,
  output logic signed [7:0]  servo_angle
);

  function automatic logic signed [7:0] clamp32(input logic signed [31:0] v,
                                                input logic [6:0] lim);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [7:0]  res;
    hi = signed'({25'd0, lim});
    lo = -hi;
    if (v > hi) res = signed'({1'b0, lim});
    else if (v < lo) res = -signed'({1'b0, lim});
    else res = v[7:0];
    return res;
  endfunction

  function automatic logic signed [7:0] side(input logic signed [8:0] sum,
                                             input logic [11:0] gain,
                                             input logic invert,
                                             input logic [6:0] lim);
    logic        neg;
    logic [8:0]  abs9;
    logic [19:0] prod;
    logic [9:0]  scaled;
    logic [6:0]  capped;
    logic [7:0]  mag8;
    neg    = sum[8];
    abs9   = neg ? (~sum + 9'd1) : sum;
    prod   = abs9[7:0] * gain;
    scaled = prod[19:10];
    capped = (scaled > {3'd0, lim}) ? lim : scaled[6:0];
    mag8   = {1'b0, capped};
    return (neg ^ invert) ? signed'(-mag8) : signed'(mag8);
  endfunction

  logic signed [7:0] speed_c;
  logic signed [7:0] diff_c;
  logic signed [8:0] sum_l;
  logic signed [8:0] sum_r;
  logic [6:0]        lim;
  logic signed [7:0] drive_l;
  logic signed [7:0] drive_r;

  assign speed_c     = clamp32(speed_request, DRIVE_LIMIT);
  assign diff_c      = clamp32(diff_request, DRIVE_LIMIT);
  assign servo_angle = clamp32(steer_request, SERVO_LIMIT);

  assign sum_l = {speed_c[7], speed_c} + {diff_c[7], diff_c};
  assign sum_r = {speed_c[7], speed_c} - {diff_c[7], diff_c};
  assign lim   = (cfg.max_percent > DRIVE_LIMIT) ? DRIVE_LIMIT : cfg.max_percent;

  assign drive_l = side(sum_l, cfg.left_gain, cfg.flip_left, lim);
  assign drive_r = side(sum_r, cfg.right_gain, cfg.flip_right, lim);

  assign left_drive  = cfg.swap_sides ? drive_r : drive_l;
  assign right_drive = cfg.swap_sides ? drive_l : drive_r;

endmodule

// ----- sv/drive_command_mixer_with_failsafe.sv -----
// A request passes from the input register to the result register;
// the mixer and watchdog sit between the two.
// Throughput: one request per cycle while the result side keeps taking.
// Reset (synchronous, active high) restores all settings to their defaults,
// clears the sequence, link and watchdog state and empties both registers.
// ----------------------------------------------------------------------------
// Drive command mixer with failsafe
// Validates drive frames, mixes them into left and right motor percent and
// runs a millisecond command watchdog.
// ----------------------------------------------------------------------------
module drive_command_mixer_with_failsafe import dcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         op,
  input  logic [31:0]        frame_magic,
  input  logic signed [31:0] speed_request,
  input  logic signed [31:0] steer_request,
  input  logic signed [31:0] diff_request,
  input  logic [31:0]        sequence_req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         action,
  output logic signed [7:0]  left_drive,
  output logic signed [7:0]  right_drive,
  output logic signed [7:0]  servo_angle
);

  dcm_cfg_t    cfg;
  logic [15:0] timeout_ms;

  logic               in_full;
  logic [1:0]         op_q;
  logic [31:0]        magic_q;
  logic signed [31:0] speed_q;
  logic signed [31:0] steer_q;
  logic signed [31:0] diff_q;
  logic [31:0]        seq_q;

  logic [31:0] last_sequence;
  logic        command_active;
  logic [16:0] ms_since_command;

  logic [31:0] last_sequence_next;
  logic        command_active_next;
  logic [16:0] ms_since_command_next;
  logic [1:0]  action_next;
  logic [16:0] ms_inc;

  logic signed [7:0] mix_left;
  logic signed [7:0] mix_right;
  logic signed [7:0] mix_servo;

  logic advance;
  logic take;

  assign advance   = in_full && (!rsp_valid || rsp_ready);
  assign cmd_ready = !in_full || advance;
  assign take      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_gain    <= 12'd1024;
      cfg.right_gain   <= 12'd492;
      cfg.flip_left    <= 1'b0;
      cfg.flip_right   <= 1'b0;
      cfg.swap_sides   <= 1'b0;
      cfg.max_percent  <= 7'd100;
      timeout_ms       <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_GAIN:    cfg.left_gain    <= cfg_data[11:0];
        REG_RIGHT_GAIN:   cfg.right_gain   <= cfg_data[11:0];
        REG_FLIP_LEFT:    cfg.flip_left    <= cfg_data[0];
        REG_FLIP_RIGHT:   cfg.flip_right   <= cfg_data[0];
        REG_SWAP_SIDES:   cfg.swap_sides   <= cfg_data[0];
        REG_MAX_PERCENT:  cfg.max_percent  <= cfg_data[6:0];
        REG_TIMEOUT_MS:   timeout_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_q    <= op;
      magic_q <= frame_magic;
      speed_q <= speed_request;
      steer_q <= steer_request;
      diff_q  <= diff_request;
      seq_q   <= sequence_req;
    end
  end

  dcm_mixer u_mixer (
    .speed_request (speed_q),
    .steer_request (steer_q),
    .diff_request  (diff_q),
    .cfg           (cfg),
    .left_drive    (mix_left),
    .right_drive   (mix_right),
    .servo_angle   (mix_servo)
  );

  assign ms_inc = (ms_since_command < MS_SAT) ? ms_since_command + 17'd1 : ms_since_command;

  always_comb begin
    last_sequence_next    = last_sequence;
    command_active_next   = command_active;
    ms_since_command_next = ms_since_command;
    action_next           = ACT_NONE;
    case (op_q)
      OP_FRAME: begin
        if (magic_q == FRAME_MAGIC && !(seq_q < last_sequence && command_active)) begin
          last_sequence_next    = seq_q;
          command_active_next   = 1'b1;
          ms_since_command_next = '0;
          action_next           = ACT_SET;
        end
      end
      OP_TICK: begin
        ms_since_command_next = ms_inc;
        if (command_active && ms_inc > {1'b0, timeout_ms}) begin
          command_active_next = 1'b0;
          action_next         = ACT_STOP_CENTER;
        end
      end
      OP_CONNECT: begin
        last_sequence_next    = '0;
        command_active_next   = 1'b0;
        ms_since_command_next = '0;
        action_next           = ACT_STOP_CENTER;
      end
      default: begin
        command_active_next = 1'b0;
        action_next         = ACT_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence    <= '0;
      command_active   <= 1'b0;
      ms_since_command <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (advance) begin
        last_sequence    <= last_sequence_next;
        command_active   <= command_active_next;
        ms_since_command <= ms_since_command_next;
        rsp_valid        <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action      <= action_next;
      left_drive  <= (action_next == ACT_SET) ? mix_left : 8'sd0;
      right_drive <= (action_next == ACT_SET) ? mix_right : 8'sd0;
      servo_angle <= (action_next == ACT_SET) ? mix_servo : 8'sd0;
    end
  end

endmodule

// ----- sv/dcm_checker.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer checker
// Port-level assertions on results, bound to the top level.
// ----------------------------------------------------------------------------
`include "drive_command_mixer_with_failsafe_defines.svh"

module dcm_checker import dcm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         action,
  input logic signed [7:0]  left_drive,
  input logic signed [7:0]  right_drive,
  input logic signed [7:0]  servo_angle
);

  `DCM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(left_drive) && $stable(right_drive) && $stable(servo_angle), "result changed while stalled")
  `DCM_ASSERT(a_idle_zero, rsp_valid && action != ACT_SET |-> left_drive == 8'sd0 && right_drive == 8'sd0 && servo_angle == 8'sd0, "nonzero drive without set action")
  `DCM_ASSERT(a_range, rsp_valid |-> left_drive <= 8'sd100 && left_drive >= -8'sd100 && right_drive <= 8'sd100 && right_drive >= -8'sd100 && servo_angle <= 8'sd90 && servo_angle >= -8'sd90, "drive or servo out of range")
  `DCM_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind drive_command_mixer_with_failsafe dcm_checker u_dcm_checker (.*);
